/* src/kac_pkg.sv */
package kac_pkg;

  localparam int NUM_ALARMS  = 4;
  localparam int CMD_W       = 1;
  localparam int BUTTON_W    = 4;
  localparam int DIGIT_W     = 4;
  localparam int LINES_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int MOD_W       = 11;
  localparam int HOURS_W     = 5;
  localparam int MINUTES_W   = 6;
  localparam int SECONDS_W   = 6;
  localparam int STEP_W      = 3;
  localparam int EDIT_W      = 7;

  localparam logic [MOD_W-1:0]     ALARM_RESET = MOD_W'(720);
  localparam logic [HOURS_W-1:0]   HOURS_RESET = HOURS_W'(12);

  localparam logic [CMD_W-1:0]     CMD_TICK  = 1'b0;
  localparam logic [CMD_W-1:0]     CMD_PRESS = 1'b1;

  localparam logic [BUTTON_W-1:0]  BTN_MAX_DIGIT = 4'd9;
  localparam logic [BUTTON_W-1:0]  BTN_A = 4'd10;
  localparam logic [BUTTON_W-1:0]  BTN_B = 4'd11;
  localparam logic [BUTTON_W-1:0]  BTN_C = 4'd12;

  localparam logic [DIGIT_W-1:0]   DIGIT_BLANK = 4'd15;

  localparam logic [STEP_W-1:0]    EDIT_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0]    EDIT_H_TENS   = 3'd1;
  localparam logic [STEP_W-1:0]    EDIT_H_UNITS  = 3'd2;
  localparam logic [STEP_W-1:0]    EDIT_M_TENS   = 3'd3;
  localparam logic [STEP_W-1:0]    EDIT_M_UNITS  = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM0 = 3'd0,
    REG_ALARM1 = 3'd1,
    REG_ALARM2 = 3'd2,
    REG_ALARM3 = 3'd3,
    REG_ENABLE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_HHMM = 2'd0,
    MODE_12H  = 2'd1,
    MODE_MMSS = 2'd2
  } show_mode_e;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [STEP_W-1:0]    edit_step;
    show_mode_e           show_mode;
    logic [EDIT_W-1:0]    edit_hours;
    logic [EDIT_W-1:0]    edit_minutes;
    logic [LINES_W-1:0]   ringing;
  } clk_state_t;

  typedef struct packed {
    logic [NUM_ALARMS-1:0][MOD_W-1:0] minute_of_day;
    logic [LINES_W-1:0]               enable;
  } alarm_cfg_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_units;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [LINES_W-1:0] alarm_lines;
  } out_word_t;

  // tens digit of a value below 128, by reciprocal multiply
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [EDIT_W-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [DIGIT_W-1:0] units_of(input logic [EDIT_W-1:0] v);
    logic [EDIT_W-1:0] t10;
    t10 = EDIT_W'(tens_of(v)) * EDIT_W'(10);
    return DIGIT_W'(v - t10);
  endfunction

endpackage

/* src/kac_if.sv */
interface kac_in_if import kac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [BUTTON_W-1:0] button;

  modport source (output valid, cmd, button, input ready);
  modport sink   (input valid, cmd, button, output ready);
endinterface

interface kac_out_if import kac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_units;
  logic [DIGIT_W-1:0] digit_tens;
  logic [DIGIT_W-1:0] digit_hundreds;
  logic [DIGIT_W-1:0] digit_thousands;
  logic [LINES_W-1:0] alarm_lines;

  modport source (output valid, digit_units, digit_tens, digit_hundreds, digit_thousands,
                  alarm_lines, input ready);
  modport sink   (input valid, digit_units, digit_tens, digit_hundreds, digit_thousands,
                  alarm_lines, output ready);
endinterface

interface kac_cfg_if import kac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/kac_cfg_regs.sv */
module kac_cfg_regs import kac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kac_cfg_if.sink    cfg_i,
  output alarm_cfg_t alarm_cfg_o
);

  logic [NUM_ALARMS-1:0][MOD_W-1:0] alarm_q;
  logic [LINES_W-1:0]               enable_q;
  logic                             wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_q[i] <= ALARM_RESET;
      end
      enable_q <= '0;
    end else if (wr) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        if (cfg_i.index == CFG_IDX_W'(i)) begin
          alarm_q[i] <= cfg_i.data;
        end
      end
      if (cfg_reg_e'(cfg_i.index) == REG_ENABLE) begin
        enable_q <= cfg_i.data[LINES_W-1:0];
      end
    end
  end

  assign alarm_cfg_o.minute_of_day = alarm_q;
  assign alarm_cfg_o.enable        = enable_q;

endmodule

/* src/kac_clock_core.sv */
module kac_clock_core import kac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [BUTTON_W-1:0] button_i,
  input  alarm_cfg_t          alarm_cfg_i,
  output clk_state_t          nxt_o
);

  clk_state_t         st_q, st_d;
  logic               check;
  logic [STEP_W-1:0]  step_inc;
  logic [MOD_W-1:0]   now;

  always_comb begin
    st_d     = st_q;
    check    = 1'b0;
    step_inc = st_q.edit_step + STEP_W'(1);
    now      = '0;
    if (cmd_i == CMD_TICK) begin
      // time advance
      if (st_q.seconds >= SECONDS_W'(59)) begin
        st_d.seconds = '0;
        check        = 1'b1;
        if (st_q.minutes >= MINUTES_W'(59)) begin
          st_d.minutes = '0;
          st_d.hours   = (st_q.hours >= HOURS_W'(23)) ? '0 : st_q.hours + HOURS_W'(1);
        end else begin
          st_d.minutes = st_q.minutes + MINUTES_W'(1);
        end
      end else begin
        st_d.seconds = st_q.seconds + SECONDS_W'(1);
      end
    end else if (button_i == BTN_C) begin
      st_d.ringing = '0;
    end else if (st_q.edit_step == EDIT_IDLE) begin
      if (button_i == BTN_A) begin
        unique case (st_q.show_mode)
          MODE_HHMM: st_d.show_mode = MODE_12H;
          MODE_12H:  st_d.show_mode = MODE_MMSS;
          default:   st_d.show_mode = MODE_HHMM;
        endcase
      end else if (button_i == BTN_B) begin
        st_d.edit_step    = EDIT_H_TENS;
        st_d.edit_hours   = EDIT_W'(st_q.hours);
        st_d.edit_minutes = EDIT_W'(st_q.minutes);
      end
    end else if (button_i == BTN_B) begin
      st_d.edit_step = EDIT_IDLE;
    end else if (button_i <= BTN_MAX_DIGIT) begin
      unique case (st_q.edit_step)
        EDIT_H_TENS:  st_d.edit_hours   = EDIT_W'(button_i) * EDIT_W'(10);
        EDIT_H_UNITS: st_d.edit_hours   = st_q.edit_hours + EDIT_W'(button_i);
        EDIT_M_TENS:  st_d.edit_minutes = EDIT_W'(button_i) * EDIT_W'(10);
        EDIT_M_UNITS: st_d.edit_minutes = st_q.edit_minutes + EDIT_W'(button_i);
        default:      ;
      endcase
      st_d.edit_step = step_inc;
      if (step_inc > EDIT_M_UNITS || step_inc == EDIT_IDLE) begin
        // commit, an out-of-range entry keeps the old time
        if (st_d.edit_hours < EDIT_W'(24) && st_d.edit_minutes < EDIT_W'(60)) begin
          st_d.hours   = st_d.edit_hours[HOURS_W-1:0];
          st_d.minutes = st_d.edit_minutes[MINUTES_W-1:0];
        end
        st_d.edit_step = EDIT_IDLE;
        check          = 1'b1;
      end
    end
    // alarm compare on the updated time
    now = {st_d.hours, 6'b0} - {4'b0, st_d.hours, 2'b0} + MOD_W'(st_d.minutes);
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (check && alarm_cfg_i.enable[i] && alarm_cfg_i.minute_of_day[i] == now) begin
        st_d.ringing[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.hours        <= HOURS_RESET;
      st_q.minutes      <= '0;
      st_q.seconds      <= '0;
      st_q.edit_step    <= EDIT_IDLE;
      st_q.show_mode    <= MODE_HHMM;
      st_q.edit_hours   <= '0;
      st_q.edit_minutes <= '0;
      st_q.ringing      <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign nxt_o = st_d;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hours < HOURS_W'(24) && st_q.minutes < MINUTES_W'(60)
    && st_q.seconds < SECONDS_W'(60))
    else $error("time out of range");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.edit_step <= EDIT_M_UNITS)
    else $error("edit step out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(st_q))
    else $error("state moved without a word");

  a_ring_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cmd_i == CMD_TICK) |=> (st_q.ringing & $past(st_q.ringing))
                                      == $past(st_q.ringing))
    else $error("tick cleared an alarm line");

endmodule

/* src/kac_display.sv */
module kac_display import kac_pkg::*; (
  input  clk_state_t st_i,
  output out_word_t  word_o
);

  logic [HOURS_W-1:0]   hour_sel;
  logic [EDIT_W-1:0]    left, right;
  logic [DIGIT_W-1:0]   d0, d1, d2, d3;

  always_comb begin
    hour_sel = st_i.hours;
    left     = '0;
    right    = '0;
    d0       = '0;
    d1       = '0;
    d2       = '0;
    d3       = '0;
    if (st_i.edit_step == EDIT_IDLE) begin
      if (st_i.show_mode == MODE_12H) begin
        if (st_i.hours > HOURS_W'(12)) begin
          hour_sel = st_i.hours - HOURS_W'(12);
        end else if (st_i.hours == '0) begin
          hour_sel = HOURS_W'(12);
        end
      end
      if (st_i.show_mode == MODE_MMSS) begin
        left  = EDIT_W'(st_i.minutes);
        right = EDIT_W'(st_i.seconds);
      end else begin
        left  = EDIT_W'(hour_sel);
        right = EDIT_W'(st_i.minutes);
      end
      d0 = units_of(right);
      d1 = tens_of(right);
      d2 = units_of(left);
      d3 = (left > EDIT_W'(9)) ? tens_of(left) : DIGIT_BLANK;
    end else begin
      d0 = units_of(st_i.edit_minutes);
      d1 = tens_of(st_i.edit_minutes);
      d2 = units_of(st_i.edit_hours);
      d3 = tens_of(st_i.edit_hours);
      // blink the digit under entry on odd seconds
      if (st_i.seconds[0]) begin
        unique case (st_i.edit_step)
          EDIT_H_TENS:  d3 = DIGIT_BLANK;
          EDIT_H_UNITS: d2 = DIGIT_BLANK;
          EDIT_M_TENS:  d1 = DIGIT_BLANK;
          EDIT_M_UNITS: d0 = DIGIT_BLANK;
          default:      ;
        endcase
      end
    end
  end

  assign word_o.digit_units     = d0;
  assign word_o.digit_tens      = d1;
  assign word_o.digit_hundreds  = d2;
  assign word_o.digit_thousands = d3;
  assign word_o.alarm_lines     = st_i.ringing;

endmodule

/* src/keypad_alarm_clock.sv */
// keypad alarm clock, 24-hour time of day with four alarms and a keypad editor
// in_i takes one word per tick or key press: cmd 0 is a one-second tick,
// cmd 1 a button press (0-9 digits, 10 mode, 11 edit/cancel, 12 stop alarms).
// out_o returns exactly one word per input word: four display digits
// (15 is blank) and the alarm lines, in input order.
// cfg_i writes alarm times (index 0-3, minute of day) and the enable mask
// (index 4); write it only while no word is in flight.
// a word accepted into the input register moves into the output register once
// out_o is not stalling; the time update is combinational logic between the two
// registers, so one word per cycle is sustained while out_o does not stall.
// when out_o stalls, the input register holds one more word and in_i drops
// ready; nothing is lost.
// reset: time 12:00:00, HH:MM mode, no edit, lines clear, alarms at 12:00
// and all disabled.
module keypad_alarm_clock import kac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kac_in_if.sink     in_i,
  kac_out_if.source  out_o,
  kac_cfg_if.sink    cfg_i
);

  logic                in_vld_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [BUTTON_W-1:0] button_q;
  logic                out_vld_q;
  out_word_t           out_q, out_d;
  logic                step;
  alarm_cfg_t          alarm_cfg;
  clk_state_t          nxt;

  assign step       = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q    <= in_i.cmd;
      button_q <= in_i.button;
    end
  end

  kac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .alarm_cfg_o (alarm_cfg)
  );

  kac_clock_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (cmd_q),
    .button_i    (button_q),
    .alarm_cfg_i (alarm_cfg),
    .nxt_o       (nxt)
  );

  kac_display u_disp (
    .st_i   (nxt),
    .word_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.digit_units     = out_q.digit_units;
  assign out_o.digit_tens      = out_q.digit_tens;
  assign out_o.digit_hundreds  = out_q.digit_hundreds;
  assign out_o.digit_thousands = out_q.digit_thousands;
  assign out_o.alarm_lines     = out_q.alarm_lines;

endmodule
